// ----- rtl/tid_pkg.sv -----
// ----------------------------------------------------------------------------
// tid_pkg
// Shared types and constants of the Tomasulo issue/dispatch/writeback engine.
// ----------------------------------------------------------------------------
package tid_pkg;

  localparam int DEF_NUM_REGS        = 5;
  localparam int DEF_ADD_STATIONS    = 3;
  localparam int DEF_MULDIV_STATIONS = 2;
  localparam int NUM_UNITS           = 3;
  localparam int MAX_WB              = 3;
  localparam int WB_CNT_W            = $clog2(MAX_WB + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] UNIT_ADD = 2'd0;
  localparam logic [1:0] UNIT_MUL = 2'd1;
  localparam logic [1:0] UNIT_DIV = 2'd2;

  localparam logic [1:0] CFG_ADD_LAT = 2'd0;
  localparam logic [1:0] CFG_MUL_LAT = 2'd1;
  localparam logic [1:0] CFG_DIV_LAT = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WB     = 1'b1;

  localparam logic [7:0] RST_ADD_LAT = 8'd1;
  localparam logic [7:0] RST_MUL_LAT = 8'd4;
  localparam logic [7:0] RST_DIV_LAT = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_WB_CHECK,
    ST_WB_WAIT,
    ST_WB_APPLY,
    ST_SEND_STATUS,
    ST_SEND_WB
  } tid_state_t;

  typedef struct packed {
    logic accept;
    logic idx_clear;
    logic idx_inc;
    logic disp_step;
    logic wb_start;
    logic wb_apply;
    logic load_status;
    logic load_wb;
    logic tick_done;
  } tid_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic wb_hit;
    logic div_busy;
    logic out_free;
    logic wb_pending;
  } tid_stat_t;

  function automatic logic [1:0] unit_of(input logic [2:0] op);
    if (op < OP_MUL) return UNIT_ADD;
    return (op == OP_MUL) ? UNIT_MUL : UNIT_DIV;
  endfunction

endpackage

// ----- rtl/tid_ifs.sv -----
// ----------------------------------------------------------------------------
// tid channel interfaces
// Instruction, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tid_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] opcode;
  logic [2:0] dest_reg;
  logic       first_is_reg;
  logic [3:0] first_operand;
  logic       second_is_reg;
  logic [3:0] second_operand;
  modport source (output valid, cmd, opcode, dest_reg, first_is_reg, first_operand,
                  second_is_reg, second_operand, input ready);
  modport sink (input valid, cmd, opcode, dest_reg, first_is_reg, first_operand,
                second_is_reg, second_operand, output ready);
endinterface

interface tid_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        cycle_number;
  logic               issued;
  logic [2:0]         issue_tag;
  logic               all_idle;
  logic               changed;
  logic [2:0]         wb_tag;
  logic signed [31:0] wb_value;
  logic [4:0]         wb_reg_mask;
  logic               last;
  modport source (output valid, kind, cycle_number, issued, issue_tag, all_idle, changed,
                  wb_tag, wb_value, wb_reg_mask, last, input ready);
  modport sink (input valid, kind, cycle_number, issued, issue_tag, all_idle, changed,
                wb_tag, wb_value, wb_reg_mask, last, output ready);
endinterface

interface tid_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tid_div.sv -----
// ----------------------------------------------------------------------------
// tid_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tid_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic [31:0] q
);
  import tid_pkg::*;

  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] mb;
  logic        neg;
  logic        zero;
  logic [4:0]  cnt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem[31:0], quo[31]};
  assign rem_sub = rem_sh - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= a[31] ? (32'd0 - a) : a;
      mb   <= b[31] ? (32'd0 - b) : b;
      neg  <= a[31] ^ b[31];
      zero <= (b == 32'd0);
    end else if (busy) begin
      if (!rem_sub[32]) begin
        rem <= rem_sub;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  assign q = zero ? 32'd0 : (neg ? (32'd0 - quo) : quo);

endmodule

// ----- rtl/tid_ctrl.sv -----
// ----------------------------------------------------------------------------
// tid_ctrl
// Tick sequencer: issue, dispatch sweep, writeback sweep, result delivery.
// ----------------------------------------------------------------------------
module tid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tid_pkg::tid_stat_t stat,
  output tid_pkg::tid_cmd_t  cmd
);
  import tid_pkg::*;

  tid_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.disp_step = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = ST_WB_CHECK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_WB_CHECK: begin
        if (stat.wb_hit) begin
          cmd.wb_start = 1'b1;
          state_next   = ST_WB_WAIT;
        end else if (stat.idx_last) begin
          state_next = ST_SEND_STATUS;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_WB_WAIT: begin
        if (!stat.div_busy) state_next = ST_WB_APPLY;
      end
      ST_WB_APPLY: begin
        cmd.wb_apply = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_SEND_STATUS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_WB_CHECK;
        end
      end
      ST_SEND_STATUS: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = ST_SEND_WB;
        end
      end
      ST_SEND_WB: begin
        if (!stat.wb_pending) begin
          cmd.tick_done = 1'b1;
          state_next    = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.load_wb = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_status || cmd.load_wb) |-> stat.out_free)
    else $error("result word loaded over an untaken one");
  a_apply_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB_APPLY) |-> !stat.div_busy)
    else $error("writeback applied while divider running");
  a_wait_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_start |=> (state == ST_WB_WAIT))
    else $error("writeback start not followed by wait");
`endif

endmodule

// ----- rtl/tid_dp.sv -----
// ----------------------------------------------------------------------------
// tid_dp
// Datapath: rename table, stations, unit schedule, execute, result buffer.
// ----------------------------------------------------------------------------
module tid_dp #(
  parameter int NUM_REGS        = tid_pkg::DEF_NUM_REGS,
  parameter int ADD_STATIONS    = tid_pkg::DEF_ADD_STATIONS,
  parameter int MULDIV_STATIONS = tid_pkg::DEF_MULDIV_STATIONS
) (
  input  logic              clk,
  input  logic              rst,
  input  tid_pkg::tid_cmd_t  cmd,
  output tid_pkg::tid_stat_t stat,
  input  logic              in_cmd,
  input  logic [2:0]        in_opcode,
  input  logic [2:0]        in_dest_reg,
  input  logic              in_first_is_reg,
  input  logic [3:0]        in_first_operand,
  input  logic              in_second_is_reg,
  input  logic [3:0]        in_second_operand,
  tid_cfg_if.sink           cfg,
  tid_out_if.source         result
);
  import tid_pkg::*;

  localparam int NUM_ST = ADD_STATIONS + MULDIV_STATIONS;
  localparam int TAG_W  = $clog2(NUM_ST);
  localparam int REG_W  = $clog2(NUM_REGS);

  logic [7:0]       lat [NUM_UNITS];
  logic [31:0]      cyc;
  logic [31:0]      ufc [NUM_UNITS];
  logic [31:0]      regv [NUM_REGS];
  logic             rv [NUM_REGS];
  logic [TAG_W-1:0] rt [NUM_REGS];
  logic             busy [NUM_ST];
  logic [2:0]       sop [NUM_ST];
  logic             pa [NUM_ST];
  logic [TAG_W-1:0] ta [NUM_ST];
  logic [31:0]      va [NUM_ST];
  logic             pb [NUM_ST];
  logic [TAG_W-1:0] tb [NUM_ST];
  logic [31:0]      vb [NUM_ST];
  logic [31:0]      stc [NUM_ST];
  logic [31:0]      fin [NUM_ST];
  logic [TAG_W-1:0] idx;

  logic             issued, changed;
  logic [TAG_W-1:0] itag;
  logic [2:0]       cur_op;
  logic [31:0]      res;
  logic             div_busy;
  logic [31:0]      div_q;
  logic [31:0]      wb_val;

  logic [2:0]        bt [MAX_WB];
  logic [31:0]       bv [MAX_WB];
  logic [4:0]        bm [MAX_WB];
  logic [WB_CNT_W-1:0] cnt, rd;

  // issue selection
  logic             ok, found, is_add;
  logic [TAG_W-1:0] sel;
  logic [REG_W-1:0] didx, fidx, sidx;
  logic             f_pend, s_pend;
  logic [31:0]      f_val, s_val;

  // dispatch / writeback terms
  logic [1:0]  du;
  logic [7:0]  dlat;
  logic [31:0] dst, dfin;
  logic        all_idle;
  logic [NUM_REGS-1:0] wmask;
  logic [31:0] wmask32;

  always_comb begin
    is_add = in_opcode < OP_MUL;
    didx   = REG_W'(in_dest_reg);
    fidx   = REG_W'(in_first_operand);
    sidx   = REG_W'(in_second_operand);
    ok     = (in_opcode <= OP_DIV) && (32'(in_dest_reg) < NUM_REGS)
          && (!in_first_is_reg || (32'(in_first_operand) < NUM_REGS))
          && (!in_second_is_reg || (32'(in_second_operand) < NUM_REGS));
    found  = 1'b0;
    sel    = '0;
    for (int s = 0; s < NUM_ST; s++) begin
      if (!found && !busy[s] && ((s < ADD_STATIONS) == is_add)) begin
        found = 1'b1;
        sel   = TAG_W'(s);
      end
    end
    f_pend = in_first_is_reg && rv[fidx];
    s_pend = in_second_is_reg && rv[sidx];
    f_val  = f_pend ? 32'd0 : (in_first_is_reg ? regv[fidx] : 32'(in_first_operand));
    s_val  = s_pend ? 32'd0 : (in_second_is_reg ? regv[sidx] : 32'(in_second_operand));
  end

  always_comb begin
    du   = unit_of(sop[idx]);
    dlat = (lat[du] == 8'd0) ? 8'd1 : lat[du];
    dst  = (cyc >= ufc[du]) ? (cyc + 32'd1) : ufc[du];
    dfin = dst + 32'(dlat);
  end

  assign wb_val = (cur_op == OP_DIV) ? div_q : res;

  always_comb begin
    all_idle = 1'b1;
    for (int s = 0; s < NUM_ST; s++) if (busy[s]) all_idle = 1'b0;
    for (int j = 0; j < NUM_REGS; j++) if (rv[j]) all_idle = 1'b0;
    for (int j = 0; j < NUM_REGS; j++) wmask[j] = rv[j] && (rt[j] == idx);
    wmask32 = 32'(wmask);
  end

  assign stat.idx_last   = (32'(idx) == NUM_ST - 1);
  assign stat.wb_hit     = busy[idx] && (fin[idx] != 32'd0) && (fin[idx] == cyc);
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !result.valid || result.ready;
  assign stat.wb_pending = (rd != cnt);

  assign cfg.ready = 1'b1;

  tid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.wb_start && (sop[idx] == OP_DIV)),
    .a     (va[idx]),
    .b     (vb[idx]),
    .busy  (div_busy),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lat[UNIT_ADD] <= RST_ADD_LAT;
      lat[UNIT_MUL] <= RST_MUL_LAT;
      lat[UNIT_DIV] <= RST_DIV_LAT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ADD_LAT: lat[UNIT_ADD] <= cfg.data;
        CFG_MUL_LAT: lat[UNIT_MUL] <= cfg.data;
        CFG_DIV_LAT: lat[UNIT_DIV] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cyc     <= 32'd1;
      idx     <= '0;
      issued  <= 1'b0;
      changed <= 1'b0;
      itag    <= '0;
      cnt     <= '0;
      rd      <= '0;
      cur_op  <= OP_ADD;
      for (int u = 0; u < NUM_UNITS; u++) ufc[u] <= 32'd0;
      for (int j = 0; j < NUM_REGS; j++) begin
        regv[j] <= 32'(j * 2);
        rv[j]   <= 1'b0;
        rt[j]   <= '0;
      end
      for (int s = 0; s < NUM_ST; s++) begin
        busy[s] <= 1'b0;
        sop[s]  <= OP_ADD;
        pa[s]   <= 1'b0;
        ta[s]   <= '0;
        pb[s]   <= 1'b0;
        tb[s]   <= '0;
        stc[s]  <= 32'd0;
        fin[s]  <= 32'd0;
      end
    end else begin
      if (cmd.idx_clear)    idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;

      if (cmd.accept) begin
        cnt     <= '0;
        rd      <= '0;
        issued  <= 1'b0;
        changed <= 1'b0;
        itag    <= '0;
        if (in_cmd && ok && found) begin
          busy[sel] <= 1'b1;
          sop[sel]  <= in_opcode;
          pa[sel]   <= f_pend;
          ta[sel]   <= f_pend ? rt[fidx] : '0;
          va[sel]   <= f_val;
          pb[sel]   <= s_pend;
          tb[sel]   <= s_pend ? rt[sidx] : '0;
          vb[sel]   <= s_val;
          stc[sel]  <= 32'd0;
          fin[sel]  <= 32'd0;
          rv[didx]  <= 1'b1;
          rt[didx]  <= sel;
          issued    <= 1'b1;
          changed   <= 1'b1;
          itag      <= sel;
        end
      end

      if (cmd.disp_step && busy[idx] && !pa[idx] && !pb[idx] && (stc[idx] == 32'd0)) begin
        stc[idx] <= dst;
        fin[idx] <= dfin;
        ufc[du]  <= dfin;
      end

      if (cmd.wb_start) begin
        cur_op <= sop[idx];
        case (sop[idx])
          OP_SUB:  res <= va[idx] - vb[idx];
          OP_MUL:  res <= va[idx] * vb[idx];
          default: res <= va[idx] + vb[idx];
        endcase
      end

      if (cmd.wb_apply) begin
        for (int j = 0; j < NUM_REGS; j++) begin
          if (wmask[j]) begin
            rv[j]   <= 1'b0;
            rt[j]   <= '0;
            regv[j] <= wb_val;
          end
        end
        busy[idx] <= 1'b0;
        sop[idx]  <= OP_ADD;
        pa[idx]   <= 1'b0;
        ta[idx]   <= '0;
        pb[idx]   <= 1'b0;
        tb[idx]   <= '0;
        stc[idx]  <= 32'd0;
        fin[idx]  <= 32'd0;
        // broadcast to waiting operands
        for (int s = 0; s < NUM_ST; s++) begin
          if (busy[s] && pa[s] && ta[s] == idx) begin
            pa[s] <= 1'b0;
            ta[s] <= '0;
            va[s] <= wb_val;
          end
          if (busy[s] && pb[s] && tb[s] == idx) begin
            pb[s] <= 1'b0;
            tb[s] <= '0;
            vb[s] <= wb_val;
          end
        end
        changed <= 1'b1;
        if (32'(cnt) < MAX_WB) begin
          bt[cnt] <= 3'(idx);
          bv[cnt] <= wb_val;
          bm[cnt] <= wmask32[4:0];
          cnt     <= cnt + 1'b1;
        end
      end

      if (cmd.load_wb) rd <= rd + 1'b1;
      if (cmd.tick_done) cyc <= cyc + 32'd1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_wb) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      result.kind         <= KIND_STATUS;
      result.cycle_number <= cyc;
      result.issued       <= issued;
      result.issue_tag    <= 3'(itag);
      result.all_idle     <= all_idle;
      result.changed      <= changed;
      result.wb_tag       <= 3'd0;
      result.wb_value     <= 32'sd0;
      result.wb_reg_mask  <= 5'd0;
      result.last         <= (cnt == '0);
    end else if (cmd.load_wb) begin
      result.kind         <= KIND_WB;
      result.cycle_number <= cyc;
      result.issued       <= 1'b0;
      result.issue_tag    <= 3'd0;
      result.all_idle     <= 1'b0;
      result.changed      <= 1'b0;
      result.wb_tag       <= bt[rd];
      result.wb_value     <= bv[rd];
      result.wb_reg_mask  <= bm[rd];
      result.last         <= ((rd + 1'b1) == cnt);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(cnt) <= MAX_WB) && (rd <= cnt))
    else $error("result buffer pointers out of range");
  a_apply_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_apply |=> !busy[$past(idx)])
    else $error("station still busy after writeback");
  a_issue_class: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && in_cmd && ok && found) |=> issued && busy[itag])
    else $error("issued instruction has no busy station");
`endif

endmodule

// ----- rtl/tomasulo_issue_dispatch_writeback.sv -----
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_writeback
// Tomasulo-style issue, dispatch and writeback engine; each issue word is one modeled tick.
// ----------------------------------------------------------------------------
// Channels: issue (sink) takes one tick word, optionally offering an
// instruction; result (source) returns a status word followed by up to three
// writeback words, the final one flagged with last; cfg writes the three unit
// latencies (index 0 add/sub, 1 mul, 2 div) and is always ready.
// A tick is taken only when the previous tick's words are all queued. It then
// runs issue, a dispatch sweep over the stations and a writeback check of
// each station; a writeback starts the unit result (a divide runs the divider,
// one quotient bit per cycle) and then applies it; last come the result words
// and the close of the tick. Each unit finishes at most one instruction per
// tick, so the worst tick has an add, a multiply and a divide writing back
// together.
// Reset (rst, synchronous) restores cycle 1, registers 0,2,4,6,8, no renames,
// free stations and latencies 1/4/8; there is no clearing pass.
// A stalled receiver holds the result word in its register; the sequencer
// waits and the issue channel stays not ready until the last word is loaded.
// ----------------------------------------------------------------------------
module tomasulo_issue_dispatch_writeback #(
  parameter int NUM_REGS        = tid_pkg::DEF_NUM_REGS,
  parameter int ADD_STATIONS    = tid_pkg::DEF_ADD_STATIONS,
  parameter int MULDIV_STATIONS = tid_pkg::DEF_MULDIV_STATIONS
) (
  input  logic      clk,
  input  logic      rst,
  tid_in_if.sink    issue,
  tid_out_if.source result,
  tid_cfg_if.sink   cfg
);
  import tid_pkg::*;

  tid_cmd_t  cmd;
  tid_stat_t stat;
  logic      in_ready;

  assign issue.ready = in_ready;

  tid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (issue.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tid_dp #(
    .NUM_REGS        (NUM_REGS),
    .ADD_STATIONS    (ADD_STATIONS),
    .MULDIV_STATIONS (MULDIV_STATIONS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (issue.cmd),
    .in_opcode         (issue.opcode),
    .in_dest_reg       (issue.dest_reg),
    .in_first_is_reg   (issue.first_is_reg),
    .in_first_operand  (issue.first_operand),
    .in_second_is_reg  (issue.second_is_reg),
    .in_second_operand (issue.second_operand),
    .cfg               (cfg),
    .result            (result)
  );

endmodule

// ----- sim/tomasulo_issue_dispatch_writeback_test.sv -----
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_writeback_test
// Drives tick words, some offering instructions, through the issue channel.
// A behavioral copy of the rename table, stations and units predicts every
// status and writeback word, and each result word is checked field by field.
// Latencies are rewritten between phases, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tomasulo_issue_dispatch_writeback_test;
  import tid_pkg::*;

  localparam int NREG = 5;
  localparam int NADD = 3;
  localparam int NST  = 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;

  typedef struct {
    logic       cmd;
    logic [2:0] opcode;
    logic [2:0] dest;
    logic       f_reg;
    logic [3:0] f_opnd;
    logic       s_reg;
    logic [3:0] s_opnd;
    int         typed_issued; // -1: take it from the engine copy
  } tick_t;

  typedef struct {
    logic        kind;
    logic [31:0] cycle_number;
    logic        issued;
    logic [2:0]  issue_tag;
    logic        all_idle;
    logic        changed;
    logic [2:0]  wb_tag;
    logic [31:0] wb_value;
    logic [4:0]  wb_reg_mask;
    logic        last;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tid_in_if  issue();
  tid_out_if result();
  tid_cfg_if cfg();

  tomasulo_issue_dispatch_writeback uut (
    .clk(clk), .rst(rst), .issue(issue), .result(result), .cfg(cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // engine copy
  logic [7:0]  lat [3];
  logic [31:0] cyc_cnt;
  logic [31:0] regv [NREG];
  logic        ren_v [NREG];
  logic [2:0]  ren_t [NREG];
  logic        busy [NST];
  logic [2:0]  sop [NST];
  logic        a_pend [NST], b_pend [NST];
  logic [2:0]  a_tag [NST], b_tag [NST];
  logic [31:0] a_val [NST], b_val [NST];
  logic [31:0] st_cyc [NST], fin_cyc [NST];
  logic [31:0] ufree [3];

  word_t pending_words[$];
  int    fails = 0;
  int    n_ticks = 0, n_issued = 0, n_wb = 0, n_words = 0;
  bit    no_idle = 1'b0;
  bit    hold_req = 1'b0;

  function automatic logic [31:0] alu_result(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (op == OP_ADD || op == OP_ADDI) return a + b;
    if (op == OP_SUB) return a - b;
    if (op == OP_MUL) return a * b;
    if (b == 0) return 32'd0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic void clear_station(int s);
    busy[s] = 0; sop[s] = 0;
    a_pend[s] = 0; a_tag[s] = 0; a_val[s] = 0;
    b_pend[s] = 0; b_tag[s] = 0; b_val[s] = 0;
    st_cyc[s] = 0; fin_cyc[s] = 0;
  endfunction

  function automatic void reset_engine();
    lat[0] = RST_ADD_LAT; lat[1] = RST_MUL_LAT; lat[2] = RST_DIV_LAT;
    cyc_cnt = 1;
    for (int i = 0; i < NREG; i++) begin
      regv[i] = 32'(i * 2); ren_v[i] = 0; ren_t[i] = 0;
    end
    for (int s = 0; s < NST; s++) clear_station(s);
    for (int u = 0; u < 3; u++) ufree[u] = 0;
  endfunction

  function automatic void read_source(logic is_reg, logic [3:0] v, output logic pend,
                                      output logic [2:0] tag, output logic [31:0] val);
    if (is_reg && ren_v[v]) begin
      pend = 1; tag = ren_t[v]; val = 0;
    end else begin
      pend = 0; tag = 0; val = is_reg ? regv[v] : {28'd0, v};
    end
  endfunction

  // one tick: issue, dispatch, writeback; queues the words it produces
  function automatic void advance_engine(tick_t t);
    logic [31:0] cyc, val, sc, lt;
    logic [4:0]  mask;
    logic        iss, chg, idle, ok;
    logic [2:0]  itag;
    logic [1:0]  u;
    int          lo, hi, s, nres;
    word_t       w, wbw[$];
    cyc = cyc_cnt; iss = 0; chg = 0; itag = 0; nres = 1;
    if (t.cmd) begin
      ok = t.opcode <= OP_DIV && t.dest < NREG && (!t.f_reg || t.f_opnd < NREG)
           && (!t.s_reg || t.s_opnd < NREG);
      if (ok) begin
        lo = t.opcode < OP_MUL ? 0 : NADD;
        hi = t.opcode < OP_MUL ? NADD : NST;
        for (s = lo; s < hi; s++) if (!busy[s]) break;
        if (s < hi) begin
          clear_station(s);
          busy[s] = 1; sop[s] = t.opcode;
          read_source(t.f_reg, t.f_opnd, a_pend[s], a_tag[s], a_val[s]);
          read_source(t.s_reg, t.s_opnd, b_pend[s], b_tag[s], b_val[s]);
          ren_v[t.dest] = 1; ren_t[t.dest] = 3'(s);
          iss = 1; itag = 3'(s); chg = 1;
        end
      end
    end
    for (s = 0; s < NST; s++) begin
      if (busy[s] && !a_pend[s] && !b_pend[s] && st_cyc[s] == 0) begin
        u = (sop[s] < OP_MUL) ? UNIT_ADD : (sop[s] == OP_MUL ? UNIT_MUL : UNIT_DIV);
        lt = (lat[u] == 0) ? 32'd1 : {24'd0, lat[u]};
        sc = (cyc >= ufree[u]) ? cyc + 1 : ufree[u];
        st_cyc[s] = sc; fin_cyc[s] = sc + lt; ufree[u] = fin_cyc[s];
      end
    end
    for (s = 0; s < NST; s++) begin
      if (busy[s] && fin_cyc[s] != 0 && fin_cyc[s] == cyc) begin
        val = alu_result(sop[s], a_val[s], b_val[s]);
        mask = 0;
        for (int j = 0; j < NREG; j++) begin
          if (ren_v[j] && ren_t[j] == s) begin
            ren_v[j] = 0; ren_t[j] = 0; regv[j] = val; mask[j] = 1;
          end
        end
        clear_station(s);
        for (int j = 0; j < NST; j++) begin
          if (!busy[j]) continue;
          if (a_pend[j] && a_tag[j] == s) begin a_pend[j] = 0; a_tag[j] = 0; a_val[j] = val; end
          if (b_pend[j] && b_tag[j] == s) begin b_pend[j] = 0; b_tag[j] = 0; b_val[j] = val; end
        end
        chg = 1;
        if (nres < 4) begin
          w = '{KIND_WB, cyc, 0, 0, 0, 0, s[2:0], val, mask, 0};
          wbw = {wbw, w};
          nres++;
        end
      end
    end
    idle = 1;
    for (s = 0; s < NST; s++) if (busy[s]) idle = 0;
    for (int j = 0; j < NREG; j++) if (ren_v[j]) idle = 0;
    w = '{KIND_STATUS, cyc, iss, itag, idle, chg, 0, 0, 0, 0};
    if (t.typed_issued >= 0) w.issued = t.typed_issued[0];
    if (wbw.size() == 0) w.last = 1;
    else wbw[wbw.size() - 1].last = 1;
    pending_words = {pending_words, w};
    foreach (wbw[i]) pending_words = {pending_words, wbw[i]};
    n_issued += iss;
    n_wb += wbw.size();
    cyc_cnt = cyc + 1;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp, act);
      fails++;
    end
  endfunction

  int quiet_cycles = 0;

  always @(posedge clk) begin
    word_t e;
    if (!rst && result.valid && result.ready) begin
      n_words++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected (cycle_number %0d)", result.cycle_number);
        fails++;
      end else begin
        e = pending_words.pop_front();
        check_field("kind", e.kind, result.kind);
        check_field("cycle_number", e.cycle_number, result.cycle_number);
        check_field("issued", e.issued, result.issued);
        check_field("issue_tag", e.issue_tag, result.issue_tag);
        check_field("all_idle", e.all_idle, result.all_idle);
        check_field("changed", e.changed, result.changed);
        check_field("wb_tag", e.wb_tag, result.wb_tag);
        check_field("wb_value", e.wb_value, result.wb_value);
        check_field("wb_reg_mask", e.wb_reg_mask, result.wb_reg_mask);
        check_field("last", e.last, result.last);
      end
    end
    if ((issue.valid && issue.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[tomasulo_issue_dispatch_writeback] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_tick(tick_t t);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 7) begin
      issue.valid <= 1'b0;
      @(negedge clk);
    end
    issue.valid <= 1'b1;
    issue.cmd <= t.cmd;
    issue.opcode <= t.opcode;
    issue.dest_reg <= t.dest;
    issue.first_is_reg <= t.f_reg;
    issue.first_operand <= t.f_opnd;
    issue.second_is_reg <= t.s_reg;
    issue.second_operand <= t.s_opnd;
    @(posedge clk);
    while (!issue.ready) @(posedge clk);
    advance_engine(t);
    n_ticks++;
  endtask

  // let every expected word arrive, then give the engine time to settle
  task automatic drain();
    @(negedge clk);
    issue.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_latency(logic [1:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    lat[idx] = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(99) < 10) begin
      // noise: any bit pattern
      t = '{1'($urandom_range(1)), 3'($urandom_range(7)), 3'($urandom_range(7)),
            1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
            4'($urandom_range(15)), -1};
    end else begin
      t.cmd = $urandom_range(99) < 80;
      t.opcode = 3'($urandom_range(OP_DIV));
      t.dest = 3'($urandom_range(NREG - 1));
      t.f_reg = $urandom_range(99) < 70;
      t.f_opnd = 4'(t.f_reg ? $urandom_range(NREG - 1) : $urandom_range(15));
      t.s_reg = $urandom_range(99) < 60;
      t.s_opnd = 4'(t.s_reg ? $urandom_range(NREG - 1) : $urandom_range(15));
      t.typed_issued = -1;
    end
    return t;
  endfunction

  tick_t directed [] = '{
    '{0, OP_ADD,  0, 1, 1, 1, 2, 0},   // plain tick
    '{1, OP_ADD,  0, 1, 1, 1, 2, 1},
    '{1, OP_ADDI, 1, 0, 15, 0, 15, 1}, // largest immediates
    '{1, OP_SUB,  2, 0, 0, 1, 4, 1},
    '{1, OP_MUL,  3, 1, 4, 1, 4, 1},
    '{1, OP_DIV,  4, 1, 3, 0, 0, 1},   // divide by zero
    '{1, 3'd7,    0, 1, 0, 1, 0, 0},   // bad opcode
    '{1, 3'd5,    0, 0, 1, 0, 1, 0},
    '{1, OP_ADD,  3'd7, 1, 0, 1, 0, 0},// destination out of range
    '{1, OP_ADD,  0, 1, 4'd9, 1, 0, 0},// source register out of range
    '{1, OP_SUB,  0, 1, 0, 1, 4'd5, 0},
    '{1, OP_ADD,  1, 1, 1, 1, 1, -1},  // same register in and out
    '{1, OP_ADD,  2, 1, 1, 0, 3, -1},
    '{1, OP_ADD,  3, 1, 2, 1, 1, -1},
    '{1, OP_ADD,  4, 1, 3, 1, 2, -1},  // may find the add stations full
    '{1, OP_DIV,  0, 1, 4, 1, 2, -1},
    '{1, OP_MUL,  1, 1, 0, 1, 0, -1},
    '{1, OP_DIV,  2, 1, 1, 1, 0, -1},  // mul/div stations likely full
    '{0, OP_ADD,  0, 0, 0, 0, 0, -1},
    '{1, OP_SUB,  4, 0, 0, 0, 15, -1}, // negative result
    '{1, OP_DIV,  3, 1, 4, 0, 2, -1},
    '{1, OP_MUL,  4, 1, 4, 1, 4, -1},
    '{0, 3'd7,    3'd7, 1, 4'd15, 1, 4'd15, -1}
  };

  initial begin
    issue.valid = 1'b0;
    issue.cmd = 1'b0;
    issue.opcode = OP_ADD;
    issue.dest_reg = 3'd0;
    issue.first_is_reg = 1'b0;
    issue.first_operand = 4'd0;
    issue.second_is_reg = 1'b0;
    issue.second_operand = 4'd0;
    cfg.valid = 1'b0;
    cfg.index = CFG_ADD_LAT;
    cfg.data = 8'd0;
    reset_engine();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset latencies
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    // shortest latencies, a zero among them
    write_latency(CFG_ADD_LAT, 8'd0);
    write_latency(CFG_MUL_LAT, 8'd1);
    write_latency(CFG_DIV_LAT, 8'd1);
    no_idle = 1'b1;
    repeat (30) send_tick(random_tick());
    no_idle = 1'b0;
    // receiver holds off while words keep coming
    hold_req = 1'b1;
    repeat (30) send_tick(random_tick());
    drain();

    // middle settings
    write_latency(CFG_ADD_LAT, 8'd2);
    write_latency(CFG_MUL_LAT, 8'd6);
    write_latency(CFG_DIV_LAT, 8'd13);
    repeat (80) send_tick(random_tick());
    drain();

    // longest latencies, few random ticks, then empty ticks
    write_latency(CFG_ADD_LAT, 8'd255);
    write_latency(CFG_MUL_LAT, 8'd255);
    write_latency(CFG_DIV_LAT, 8'd255);
    repeat (10) send_tick(random_tick());
    repeat (50) send_tick('{0, OP_ADD, 0, 0, 0, 0, 0, -1});
    drain();

    $display("ran %0d ticks, %0d instructions issued, %0d writebacks, %0d words checked",
             n_ticks, n_issued, n_wb, n_words);
    $display("latency phases: reset, minimum/zero, middle, maximum; %0d mismatches", fails);
    if (fails == 0 && pending_words.size() == 0)
      $display("[tomasulo_issue_dispatch_writeback] OK");
    else
      $display("[tomasulo_issue_dispatch_writeback] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tid_pkg.sv
rtl/tid_ifs.sv
rtl/tid_div.sv
rtl/tid_ctrl.sv
rtl/tid_dp.sv
rtl/tomasulo_issue_dispatch_writeback.sv
sim/tomasulo_issue_dispatch_writeback_test.sv
